/* src/vn_pkg.sv */
// ----------------------------------------------------------------------------
// vn_pkg: shared types and constants for the 2D vector normalizer
// Field widths, transaction structs and default queue depths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vn_pkg;

  // Component and fraction widths
  localparam int COMP_WIDTH = 16;
  localparam int FRAC_BITS  = 14;
  localparam int NORM_WIDTH = FRAC_BITS + 2;
  localparam int SQ_WIDTH   = 2 * COMP_WIDTH;

  // Default queue depths
  localparam int MID_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF = 2;

  // Input transaction
  typedef struct packed {
    logic signed [COMP_WIDTH-1:0] in_x;
    logic signed [COMP_WIDTH-1:0] in_y;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic signed [NORM_WIDTH-1:0] norm_x;
    logic signed [NORM_WIDTH-1:0] norm_y;
    logic        [COMP_WIDTH-1:0] length;
    logic                         was_zero;
  } out_t;

  // Classified item passed from front to back
  typedef struct packed {
    logic [COMP_WIDTH-1:0] mag_x;
    logic [COMP_WIDTH-1:0] mag_y;
    logic                  neg_x;
    logic                  neg_y;
    logic                  zero;
    logic [SQ_WIDTH-1:0]   sq;
  } mid_t;

endpackage

/* src/vn_fifo.sv */
// ----------------------------------------------------------------------------
// vn_fifo: small synchronous queue
// Flop-based storage with first-word-fall-through read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vn_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     wdata_i,
  output logic full_o,
  input  logic pop_i,
  output T     rdata_o,
  output logic empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  T               mem_q [DEPTH];
  logic [AW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == FULL_CNT);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  // Advance pointers and count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LAST) ? '0 : wr_q + AW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LAST) ? '0 : rd_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

/* src/vn_front.sv */
// ----------------------------------------------------------------------------
// vn_front: input stage of the vector normalizer
// Takes magnitudes and signs, flags zero vectors, forms the squared length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vn_front import vn_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  in_t  in_data_i,
  output logic full_o,
  output logic mid_push_o,
  output mid_t mid_data_o,
  input  logic mid_full_i
);

  logic                  v_q, v_d;
  logic [COMP_WIDTH-1:0] mx_q, my_q;
  logic                  nx_q, ny_q;
  logic                  ready, take;
  logic [SQ_WIDTH-1:0]   sqx, sqy;

  assign ready      = !v_q || !mid_full_i;
  assign full_o     = !ready;
  assign take       = push_i && ready;
  assign mid_push_o = v_q;

  // Square the held magnitudes and sum
  assign sqx = SQ_WIDTH'(mx_q) * SQ_WIDTH'(mx_q);
  assign sqy = SQ_WIDTH'(my_q) * SQ_WIDTH'(my_q);

  always_comb begin
    mid_data_o.mag_x = mx_q;
    mid_data_o.mag_y = my_q;
    mid_data_o.neg_x = nx_q;
    mid_data_o.neg_y = ny_q;
    mid_data_o.zero  = (mx_q == '0) && (my_q == '0);
    mid_data_o.sq    = sqx + sqy;
  end

  // Hold stage valid until the queue takes it
  always_comb begin
    v_d = v_q;
    if (take) begin
      v_d = 1'b1;
    end else if (v_q && !mid_full_i) begin
      v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  // Capture magnitude and sign of each component
  always_ff @(posedge clk_i) begin
    if (take) begin
      nx_q <= in_data_i.in_x[COMP_WIDTH-1];
      ny_q <= in_data_i.in_y[COMP_WIDTH-1];
      mx_q <= in_data_i.in_x[COMP_WIDTH-1] ? (~in_data_i.in_x + COMP_WIDTH'(1))
                                          : in_data_i.in_x;
      my_q <= in_data_i.in_y[COMP_WIDTH-1] ? (~in_data_i.in_y + COMP_WIDTH'(1))
                                          : in_data_i.in_y;
    end
  end

endmodule

/* src/vn_back.sv */
// ----------------------------------------------------------------------------
// vn_back: square root and divide pipeline
// One root bit per stage, then one quotient bit per stage for both lanes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vn_back import vn_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  mid_t mid_data_i,
  input  logic mid_empty_i,
  output logic mid_pop_o,
  output logic out_push_o,
  output out_t out_data_o,
  input  logic out_full_i
);

  localparam int RW = COMP_WIDTH + 2;
  localparam int QW = FRAC_BITS + 1;
  localparam int NS = COMP_WIDTH + QW;

  typedef struct packed {
    logic                  zero;
    logic                  nx;
    logic                  ny;
    logic [SQ_WIDTH-1:0]   rad;
    logic [RW-1:0]         rem;
    logic [COMP_WIDTH-1:0] root;
    logic [COMP_WIDTH-1:0] rx;
    logic [COMP_WIDTH-1:0] ry;
    logic                  bx;
    logic                  by;
    logic [QW-1:0]         qx;
    logic [QW-1:0]         qy;
  } stage_t;

  stage_t        st_q [NS];
  stage_t        st_d [NS];
  logic [NS-1:0] v_q;
  logic          en;
  stage_t        last;
  logic [NORM_WIDTH-1:0] ux, uy;

  // Stall the whole pipe only when the last result cannot leave
  assign en         = !(v_q[NS-1] && out_full_i);
  assign mid_pop_o  = en && !mid_empty_i;
  assign out_push_o = en && v_q[NS-1];

  // Load stage from the queue head
  stage_t head;
  always_comb begin
    head      = '0;
    head.zero = mid_data_i.zero;
    head.nx   = mid_data_i.neg_x;
    head.ny   = mid_data_i.neg_y;
    head.rad  = mid_data_i.sq;
    head.rx   = mid_data_i.mag_x >> 1;
    head.ry   = mid_data_i.mag_y >> 1;
    head.bx   = mid_data_i.mag_x[0];
    head.by   = mid_data_i.mag_y[0];
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    stage_t src;
    if (k == 0) begin : g_first
      assign src = head;
    end else begin : g_next
      assign src = st_q[k-1];
    end

    if (k < COMP_WIDTH) begin : g_sqrt
      // Bring down two radicand bits and try the next root bit
      logic [RW+1:0] rem2, trial;
      always_comb begin
        st_d[k] = src;
        rem2    = {src.rem, src.rad[SQ_WIDTH-1 -: 2]};
        trial   = {2'b00, src.root, 2'b01};
        st_d[k].rad = src.rad << 2;
        if (rem2 >= trial) begin
          st_d[k].rem  = RW'(rem2 - trial);
          st_d[k].root = {src.root[COMP_WIDTH-2:0], 1'b1};
        end else begin
          st_d[k].rem  = RW'(rem2);
          st_d[k].root = {src.root[COMP_WIDTH-2:0], 1'b0};
        end
      end
    end else begin : g_div
      // Shift in one dividend bit per lane and subtract the length
      logic [COMP_WIDTH:0] rrx, rry, lenx;
      logic                gex, gey;
      always_comb begin
        st_d[k] = src;
        lenx = {1'b0, src.root};
        rrx  = {src.rx, src.bx};
        rry  = {src.ry, src.by};
        gex  = (rrx >= lenx);
        gey  = (rry >= lenx);
        st_d[k].rx = gex ? COMP_WIDTH'(rrx - lenx) : COMP_WIDTH'(rrx);
        st_d[k].ry = gey ? COMP_WIDTH'(rry - lenx) : COMP_WIDTH'(rry);
        st_d[k].bx = 1'b0;
        st_d[k].by = 1'b0;
        st_d[k].qx = {src.qx[QW-2:0], gex};
        st_d[k].qy = {src.qy[QW-2:0], gey};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NS-2:0], !mid_empty_i};
    end
  end

  // Apply sign and zero case to the result
  assign last = st_q[NS-1];
  assign ux   = NORM_WIDTH'(last.qx);
  assign uy   = NORM_WIDTH'(last.qy);

  always_comb begin
    out_data_o.was_zero = last.zero;
    if (last.zero) begin
      out_data_o.norm_x = '0;
      out_data_o.norm_y = '0;
      out_data_o.length = '0;
    end else begin
      out_data_o.norm_x = last.nx ? (~ux + NORM_WIDTH'(1)) : ux;
      out_data_o.norm_y = last.ny ? (~uy + NORM_WIDTH'(1)) : uy;
      out_data_o.length = last.root;
    end
  end

endmodule

/* src/vec2_normalize.sv */
// ----------------------------------------------------------------------------
// vec2_normalize: 2D vector normalizer, Q2.14 result plus length
//
//   channel | handshake     | payload
//   --------+---------------+------------------------------------
//   input   | push / full   | in_data_i  (in_x, in_y)
//   result  | pop / empty   | out_data_o (norm_x, norm_y, length, was_zero)
//
// One transaction per cycle sustained while results are popped and no queue
// fills. Accepted inputs pass the front register, the middle queue, the
// one-bit-per-stage square root and divide pipeline and the result queue.
// Reset clears all valid state; queues come up empty.
// A full result queue stalls the back pipe; the middle queue then absorbs
// front transactions until it fills and full rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vec2_normalize import vn_pkg::*; #(
  parameter int MID_DEPTH = MID_DEPTH_DEF,
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  input  in_t  in_data_i,
  output logic full,
  output logic empty,
  input  logic pop,
  output out_t out_data_o
);

  logic mid_push, mid_full, mid_pop, mid_empty;
  mid_t mid_wdata, mid_rdata;
  logic out_push, out_full;
  out_t out_wdata;

  // Classify and square
  vn_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_data_i  (in_data_i),
    .full_o     (full),
    .mid_push_o (mid_push),
    .mid_data_o (mid_wdata),
    .mid_full_i (mid_full)
  );

  // Decouple front from back
  vn_fifo #(.T(mid_t), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .wdata_i (mid_wdata),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .rdata_o (mid_rdata),
    .empty_o (mid_empty)
  );

  // Root and divide
  vn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_data_i  (mid_rdata),
    .mid_empty_i (mid_empty),
    .mid_pop_o   (mid_pop),
    .out_push_o  (out_push),
    .out_data_o  (out_wdata),
    .out_full_i  (out_full)
  );

  // Hold finished results
  vn_fifo #(.T(out_t), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (out_wdata),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (out_data_o),
    .empty_o (empty)
  );

endmodule

/* src/vn_checker.sv */
// ----------------------------------------------------------------------------
// vn_checker: port-level checks for the vector normalizer
// Watches the result channel for holding and value consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vn_checker import vn_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic empty,
  input logic pop,
  input out_t out_data_o
);

  localparam logic signed [NORM_WIDTH-1:0] ONE   = NORM_WIDTH'(1 << FRAC_BITS);
  localparam logic signed [NORM_WIDTH-1:0] M_ONE = -ONE;

  // Hold a waiting result until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_data_o)))
    else $error("result changed while waiting");

  // Zero vector gives all-zero fields
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.was_zero) |->
      (out_data_o.norm_x == '0 && out_data_o.norm_y == '0 && out_data_o.length == '0))
    else $error("zero vector with nonzero fields");

  // Nonzero vector has nonzero length
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_data_o.was_zero) |-> (out_data_o.length != '0))
    else $error("nonzero vector with zero length");

  // Normalized components stay within unit range
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ($signed(out_data_o.norm_x) <= ONE && $signed(out_data_o.norm_x) >= M_ONE &&
                $signed(out_data_o.norm_y) <= ONE && $signed(out_data_o.norm_y) >= M_ONE))
    else $error("normalized component out of range");

endmodule

bind vec2_normalize vn_checker u_vn_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_data_o (out_data_o)
);
